// ===== rtl/register_alu_execute_unit_defines.svh =====
// ----------------------------------------------------------------------------
// register_alu_execute_unit_defines
// Assertion macros for the execute unit; clk and arst_n come from the user.
// ----------------------------------------------------------------------------
`ifndef REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RAE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg
// Command, status and ALU operation codes shared by the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rae_pkg;

	typedef logic [4:0] cmd_t;
	localparam cmd_t CMD_LIT     = 5'd0;
	localparam cmd_t CMD_JMP     = 5'd1;
	localparam cmd_t CMD_JPC     = 5'd2;
	localparam cmd_t CMD_SYSCALL = 5'd3;
	localparam cmd_t CMD_NEG     = 5'd4;
	localparam cmd_t CMD_ADD     = 5'd5;
	localparam cmd_t CMD_SUB     = 5'd6;
	localparam cmd_t CMD_MUL     = 5'd7;
	localparam cmd_t CMD_DIV     = 5'd8;
	localparam cmd_t CMD_ODD     = 5'd9;
	localparam cmd_t CMD_MOD     = 5'd10;
	localparam cmd_t CMD_EQ      = 5'd11;
	localparam cmd_t CMD_NE      = 5'd12;
	localparam cmd_t CMD_LT      = 5'd13;
	localparam cmd_t CMD_LE      = 5'd14;
	localparam cmd_t CMD_GT      = 5'd15;
	localparam cmd_t CMD_GE      = 5'd16;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_FAIL = 2'd1;
	localparam status_t ST_HALT = 2'd2;

	localparam logic [31:0] SYS_PRINT = 32'd1;
	localparam logic [31:0] SYS_READ  = 32'd2;
	localparam logic [31:0] SYS_HALT  = 32'd3;

	typedef logic [3:0] alu_op_t;
	localparam alu_op_t ALU_NEG = 4'd0;
	localparam alu_op_t ALU_ADD = 4'd1;
	localparam alu_op_t ALU_SUB = 4'd2;
	localparam alu_op_t ALU_MUL = 4'd3;
	localparam alu_op_t ALU_DIV = 4'd4;
	localparam alu_op_t ALU_MOD = 4'd5;
	localparam alu_op_t ALU_EQ  = 4'd6;
	localparam alu_op_t ALU_NE  = 4'd7;
	localparam alu_op_t ALU_LT  = 4'd8;
	localparam alu_op_t ALU_LE  = 4'd9;
	localparam alu_op_t ALU_GT  = 4'd10;
	localparam alu_op_t ALU_GE  = 4'd11;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_stat_t;

endpackage

// ===== rtl/rae_ram.sv =====
// ----------------------------------------------------------------------------
// rae_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/rae_alu.sv =====
// ----------------------------------------------------------------------------
// rae_alu
// Shared ALU around one adder: single-pass add, subtract and compares,
// shift-add multiply and restoring signed divide/modulus over many cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rae_alu import rae_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alu_req_t              req,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output alu_stat_t             stat,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int DW  = DATA_WIDTH;
	localparam int AW2 = DW + 2;
	localparam int CW  = $clog2(DW);
	localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_MAGA = 3'd1;
	localparam logic [2:0] A_MAGB = 3'd2;
	localparam logic [2:0] A_LOOP = 3'd3;
	localparam logic [2:0] A_FIX  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	alu_op_t       op_q;
	logic [DW:0]   acc_q;
	logic [DW-1:0] x_q;
	logic [DW-1:0] y_q;
	logic          neg_q;
	logic [DW-1:0] res_q;

	logic [AW2-1:0] add_x;
	logic [AW2-1:0] add_y;
	logic           add_sub;
	logic [AW2-1:0] sum;
	logic [DW:0]    shifted;
	logic [DW-1:0]  fix_val;
	logic           lt;
	logic           eq;
	logic           borrow;
	logic [DW-1:0]  simple_res;

	assign shifted = {acc_q[DW-1:0], x_q[DW-1]};
	assign fix_val = (op_q == ALU_DIV) ? x_q : acc_q[DW-1:0];

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			A_IDLE: begin
				// two sign bits so the top bit of a - b is the signed less-than
				add_x   = {a[DW-1], a[DW-1], a};
				add_y   = {b[DW-1], b[DW-1], b};
				add_sub = (req.op != ALU_ADD);
				if (req.op == ALU_NEG) begin
					add_x = '0;
					add_y = {a[DW-1], a[DW-1], a};
				end
			end
			A_MAGA: begin
				add_y   = {2'b00, x_q};
				add_sub = 1'b1;
			end
			A_MAGB: begin
				add_y   = {2'b00, y_q};
				add_sub = 1'b1;
			end
			A_LOOP: begin
				if (op_q == ALU_MUL) begin
					add_x = {1'b0, acc_q};
					add_y = x_q[0] ? {2'b00, y_q} : '0;
				end else begin
					add_x   = {1'b0, shifted};
					add_y   = {2'b00, y_q};
					add_sub = 1'b1;
				end
			end
			A_FIX: begin
				add_y   = {2'b00, fix_val};
				add_sub = 1'b1;
			end
			default: ;
		endcase
		sum = add_x + (add_sub ? ~add_y : add_y) + {{(AW2-1){1'b0}}, add_sub};
	end

	assign lt     = sum[AW2-1];
	assign eq     = (a == b);
	assign borrow = sum[AW2-1];

	always_comb begin
		unique case (req.op)
			ALU_EQ:  simple_res = {{(DW-1){1'b0}}, eq};
			ALU_NE:  simple_res = {{(DW-1){1'b0}}, !eq};
			ALU_LT:  simple_res = {{(DW-1){1'b0}}, lt};
			ALU_LE:  simple_res = {{(DW-1){1'b0}}, lt || eq};
			ALU_GT:  simple_res = {{(DW-1){1'b0}}, !lt && !eq};
			ALU_GE:  simple_res = {{(DW-1){1'b0}}, !lt};
			default: simple_res = sum[DW-1:0];
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						if (req.op == ALU_MUL) begin
							state_q <= A_LOOP;
						end else if (req.op == ALU_DIV || req.op == ALU_MOD) begin
							state_q <= A_MAGA;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				A_MAGA: state_q <= A_MAGB;
				A_MAGB: state_q <= A_LOOP;
				A_LOOP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						if (op_q == ALU_MUL) begin
							done_q  <= 1'b1;
							state_q <= A_IDLE;
						end else begin
							state_q <= A_FIX;
						end
					end
				end
				A_FIX: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					if (req.op == ALU_MUL) begin
						acc_q <= '0;
						x_q   <= b;
						y_q   <= a;
					end else if (req.op == ALU_DIV || req.op == ALU_MOD) begin
						x_q   <= a;
						y_q   <= b;
						neg_q <= (req.op == ALU_DIV) ? (a[DW-1] ^ b[DW-1]) : a[DW-1];
					end else begin
						res_q <= simple_res;
					end
				end
			end
			A_MAGA: begin
				if (x_q[DW-1]) begin
					x_q <= sum[DW-1:0];
				end
			end
			A_MAGB: begin
				if (y_q[DW-1]) begin
					y_q <= sum[DW-1:0];
				end
				acc_q <= '0;
			end
			A_LOOP: begin
				if (op_q == ALU_MUL) begin
					acc_q <= sum[DW:0];
					y_q   <= y_q << 1;
					x_q   <= x_q >> 1;
					if (cnt_q == CNT_LAST) begin
						res_q <= sum[DW-1:0];
					end
				end else begin
					acc_q <= borrow ? shifted : sum[DW:0];
					x_q   <= {x_q[DW-2:0], !borrow};
				end
			end
			A_FIX: res_q <= neg_q ? sum[DW-1:0] : fix_val;
			default: ;
		endcase
	end

	assign stat.busy = (state_q != A_IDLE);
	assign stat.done = done_q;
	assign result    = res_q;

endmodule

// ===== rtl/register_alu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// register_alu_execute_unit
// Executes one decoded instruction against a register file and a program
// counter, using a shared iterative ALU for arithmetic and compares.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_ready  command, r_index, l_index, m_value, io_value
//  out      out_valid/out_ready  status, pc_value, print_valid, print_value
//
//  One item at a time; in_ready is high only while the sequencer is idle.
//  Item time, accept to result handshake (also the input spacing), depends on the command: lit, jmp,
//  read, halt and decode failures end after decode; jpc, print and odd add a read of R;
//  a zero divisor ends after reading L and M; the other ALU ops also wait on the shared ALU,
//  whose mul, div and mod run its one-bit-per-cycle loop.
//  Reset clears the register valid bits, pc and sequencers; a result not yet taken
//  holds the following item in its last step until the receiver is ready.
//
`timescale 1ns / 1ps

`include "register_alu_execute_unit_defines.svh"

module register_alu_execute_unit import rae_pkg::*; #(
	parameter int REG_COUNT  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         command,
	input  logic [7:0]         r_index,
	input  logic [7:0]         l_index,
	input  logic signed [31:0] m_value,
	input  logic signed [31:0] io_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] pc_value,
	output logic               print_valid,
	output logic signed [31:0] print_value
);

	localparam int DW    = DATA_WIDTH;
	localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RB   = 3'd2;
	localparam logic [2:0] S_EXE  = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]           state_q, state_d;
	logic [31:0]          pc_q, pc_d;
	logic [REG_COUNT-1:0] valid_q;
	logic                 out_valid_q;

	cmd_t               cmd_q;
	logic [7:0]         r_q;
	logic [7:0]         l_q;
	logic signed [31:0] m_q;
	logic signed [31:0] io_q;
	logic [DW-1:0]      a_q;
	status_t            wst_q, wst_d;
	logic               wpv_q, wpv_d;
	logic [31:0]        wpval_q, wpval_d;
	logic               vld_rd_q;

	status_t     status_q;
	logic [31:0] pc_out_q;
	logic        print_valid_q;
	logic [31:0] print_value_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [DW-1:0]    ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [DW-1:0]    ram_rdata;
	logic [DW-1:0]    rd_val;

	logic             r_ok, l_ok, m_ok, cmd_alu;
	logic [IDX_W-1:0] r_idx, l_idx, m_idx;
	logic             out_load;

	alu_req_t      alu_req;
	alu_stat_t     alu_stat;
	logic [DW-1:0] alu_result;

	function automatic alu_op_t cmd_to_op(input cmd_t c);
		unique case (c)
			CMD_NEG: return ALU_NEG;
			CMD_SUB: return ALU_SUB;
			CMD_MUL: return ALU_MUL;
			CMD_DIV: return ALU_DIV;
			CMD_MOD: return ALU_MOD;
			CMD_EQ:  return ALU_EQ;
			CMD_NE:  return ALU_NE;
			CMD_LT:  return ALU_LT;
			CMD_LE:  return ALU_LE;
			CMD_GT:  return ALU_GT;
			CMD_GE:  return ALU_GE;
			default: return ALU_ADD;
		endcase
	endfunction

	assign r_ok    = (r_q < 8'(REG_COUNT));
	assign l_ok    = (l_q < 8'(REG_COUNT));
	// a negative m is a huge unsigned index and fails
	assign m_ok    = ($unsigned(m_q) < 32'(REG_COUNT));
	assign r_idx   = r_q[IDX_W-1:0];
	assign l_idx   = l_q[IDX_W-1:0];
	assign m_idx   = m_q[IDX_W-1:0];
	assign cmd_alu = (cmd_q >= CMD_NEG) && (cmd_q <= CMD_GE) && (cmd_q != CMD_ODD);

	// entries never written read as zero
	assign rd_val = vld_rd_q ? ram_rdata : '0;

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (state_q)
			S_DEC:   ram_raddr = cmd_alu ? l_idx : r_idx;
			S_RB:    ram_raddr = m_idx;
			default: ram_raddr = r_idx;
		endcase
	end

	always_comb begin
		state_d       = state_q;
		pc_d          = pc_q;
		wst_d         = wst_q;
		wpv_d         = wpv_q;
		wpval_d       = wpval_q;
		alu_req.start = 1'b0;
		alu_req.op    = cmd_to_op(cmd_q);
		ram_we        = 1'b0;
		ram_waddr     = r_idx;
		ram_wdata     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				wst_d   = ST_FAIL;
				wpv_d   = 1'b0;
				wpval_d = '0;
				state_d = S_FIN;
				unique case (cmd_q)
					CMD_LIT: begin
						if (r_ok) begin
							ram_we    = 1'b1;
							ram_wdata = DW'(m_q);
							wst_d     = ST_OK;
						end
					end
					CMD_JMP: begin
						pc_d  = m_q;
						wst_d = ST_OK;
					end
					CMD_JPC: begin
						if (r_ok) begin
							state_d = S_RB;
						end
					end
					CMD_SYSCALL: begin
						if (m_q == SYS_PRINT) begin
							if (r_ok) begin
								state_d = S_RB;
							end
						end else if (m_q == SYS_READ) begin
							if (r_ok) begin
								ram_we    = 1'b1;
								ram_wdata = DW'(io_q);
								wst_d     = ST_OK;
							end
						end else if (m_q == SYS_HALT) begin
							pc_d  = '0;
							wst_d = ST_HALT;
						end
					end
					CMD_NEG, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_ODD, CMD_MOD,
					CMD_EQ, CMD_NE, CMD_LT, CMD_LE, CMD_GT, CMD_GE: begin
						if (r_ok && l_ok && m_ok) begin
							state_d = S_RB;
						end
					end
					default: ;
				endcase
			end
			S_RB: begin
				// first read is back: register R for jpc/print/odd, L for ALU ops
				unique case (cmd_q)
					CMD_JPC: begin
						if (rd_val == '0) begin
							pc_d = m_q;
						end
						wst_d   = ST_OK;
						state_d = S_FIN;
					end
					CMD_SYSCALL: begin
						wpv_d   = 1'b1;
						wpval_d = 32'($signed(rd_val));
						wst_d   = ST_OK;
						state_d = S_FIN;
					end
					CMD_ODD: begin
						ram_we    = 1'b1;
						ram_wdata = {{(DW-1){1'b0}}, rd_val[0]};
						wst_d     = ST_OK;
						state_d   = S_FIN;
					end
					default: state_d = S_EXE;
				endcase
			end
			S_EXE: begin
				if ((cmd_q == CMD_DIV || cmd_q == CMD_MOD) && rd_val == '0) begin
					state_d = S_FIN;
				end else begin
					alu_req.start = 1'b1;
					state_d       = S_WAIT;
				end
			end
			S_WAIT: begin
				if (alu_stat.done) begin
					ram_we    = 1'b1;
					ram_wdata = alu_result;
					wst_d     = ST_OK;
					state_d   = S_FIN;
				end
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			r_q   <= r_index;
			l_q   <= l_index;
			m_q   <= m_value;
			io_q  <= io_value;
		end
		if (state_q == S_RB) begin
			a_q <= rd_val;
		end
		wst_q    <= wst_d;
		wpv_q    <= wpv_d;
		wpval_q  <= wpval_d;
		vld_rd_q <= valid_q[ram_raddr];
		if (out_load) begin
			status_q      <= wst_q;
			pc_out_q      <= pc_q;
			print_valid_q <= wpv_q;
			print_value_q <= wpval_q;
		end
	end

	rae_ram #(
		.WIDTH (DW),
		.DEPTH (REG_COUNT),
		.AW    (IDX_W)
	) u_regfile (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rae_alu #(
		.DATA_WIDTH (DW)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (a_q),
		.b      (rd_val),
		.stat   (alu_stat),
		.result (alu_result)
	);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pc_value    = pc_out_q;
	assign print_valid = print_valid_q;
	assign print_value = print_value_q;

	`RAE_ASSERT_NEXT(a_accept_dec, in_valid && in_ready, state_q == S_DEC, "no decode after accept")
	`RAE_ASSERT_SAME(a_alu_start, alu_req.start, !alu_stat.busy && state_q == S_EXE, "bad ALU start")
	`RAE_ASSERT_SAME(a_print_ok, out_valid_q && print_valid_q, status_q == ST_OK, "print not OK")
	`RAE_ASSERT_NEXT(a_fin_load, out_load, out_valid_q && state_q == S_IDLE, "item not presented")

endmodule
